@@ sv/assert_macros.svh @@
// assertion helpers used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define DVP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define DVP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/dvpid_pkg.sv @@
`default_nettype none

package dvpid_pkg;

  localparam int unsigned CNT_W    = 32;
  localparam int unsigned PERIOD_W = 10;
  localparam int unsigned SPEED_W  = 16;
  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned DRIVE_W  = 16;
  localparam int unsigned CFG_IDX_W = 3;

  // datapath word, wide enough for the exact pid sum
  localparam int unsigned DP_W   = 66;
  localparam int unsigned SUM_W  = 48;
  localparam int unsigned PROD_W = 51;
  localparam int unsigned MA_W   = 34;
  localparam int unsigned MB_W   = 17;
  localparam int unsigned ACC_SPLIT = 24;

  localparam int unsigned DIV_NUM_W  = 44;
  localparam int unsigned DIV_DEN_W  = PERIOD_W;
  localparam int unsigned DIV_BITS   = 4;
  localparam int unsigned DIV_STEPS  = DIV_NUM_W / DIV_BITS;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS + 1);

  localparam logic [MB_W-1:0] K_MS_PER_S = MB_W'(1000);

  localparam logic [CFG_IDX_W-1:0] REG_TGT_FWD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TGT_TRN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FWD_P   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FWD_I   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FWD_D   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TRN_P   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TRN_I   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TRN_D   = 3'd7;

  localparam logic [GAIN_W-1:0] RST_FWD_P = 16'd128;
  localparam logic [GAIN_W-1:0] RST_TRN_P = 16'd256;
  localparam logic [GAIN_W-1:0] RST_TRN_D = 16'd2560;

  typedef enum logic [2:0] {ALU_ADD, ALU_SUB, ALU_PASSA, ALU_PASSB, ALU_RND} alu_op_t;
  typedef enum logic [2:0] {SAT_NONE, SAT_W32, SAT_S16, SAT_S32, SAT_S48} sat_t;
  typedef enum logic [4:0] {
    SRC_ZERO, SRC_LC, SRC_RC, SRC_LPREV, SRC_RPREV, SRC_T0, SRC_T1, SRC_T2,
    SRC_T2LO, SRC_T2HI, SRC_PROD, SRC_PRODSH, SRC_QUOT, SRC_CHIN, SRC_TGT,
    SRC_SUM, SRC_EPREV, SRC_PX, SRC_PW
  } src_t;
  typedef enum logic [3:0] {
    DST_NONE, DST_T0, DST_T1, DST_T2, DST_CHIN0, DST_CHIN1, DST_EPREV,
    DST_SUM, DST_PCH, DST_PREV
  } dst_t;
  typedef enum logic [2:0] {MB_K1000, MB_PERIOD, MB_GP, MB_GI, MB_GD} mulb_t;
  typedef enum logic [1:0] {J_NEXT, J_WAIT, J_LOOP, J_DONE} jmp_t;

  typedef struct packed {
    alu_op_t op;
    sat_t    sat;
    src_t    a;
    src_t    b;
    dst_t    dst;
    logic    mul_en;
    src_t    ma;
    mulb_t   mb;
    logic    div_start;
    jmp_t    jmp;
  } uc_t;

  localparam int unsigned UC_LEN  = 23;
  localparam int unsigned UC_PC_W = $clog2(UC_LEN);
  localparam logic [UC_PC_W-1:0] UC_LOOP = UC_PC_W'(5);
  localparam logic [UC_PC_W-1:0] UC_EPI  = UC_PC_W'(20);

  localparam uc_t UC_NOP = '{ALU_PASSA, SAT_NONE, SRC_ZERO, SRC_ZERO, DST_NONE,
                             1'b0, SRC_ZERO, MB_K1000, 1'b0, J_NEXT};

  // control store: prologue, one pid pass run for each loop, drive mix
  function automatic uc_t uc_rom(input logic [UC_PC_W-1:0] pc);
    uc_t w;
    w = UC_NOP;
    case (pc)
      5'd0:  w = '{ALU_SUB, SAT_W32, SRC_LC, SRC_LPREV, DST_T0,
                   1'b0, SRC_ZERO, MB_K1000, 1'b0, J_NEXT};
      5'd1:  w = '{ALU_SUB, SAT_W32, SRC_RC, SRC_RPREV, DST_T1,
                   1'b0, SRC_ZERO, MB_K1000, 1'b0, J_NEXT};
      5'd2:  w = '{ALU_ADD, SAT_NONE, SRC_T1, SRC_T0, DST_CHIN0,
                   1'b0, SRC_ZERO, MB_K1000, 1'b0, J_NEXT};
      5'd3:  w = '{ALU_SUB, SAT_NONE, SRC_T1, SRC_T0, DST_CHIN1,
                   1'b0, SRC_ZERO, MB_K1000, 1'b0, J_NEXT};
      5'd4:  w = '{ALU_PASSA, SAT_NONE, SRC_ZERO, SRC_ZERO, DST_PREV,
                   1'b0, SRC_ZERO, MB_K1000, 1'b0, J_NEXT};
      // loop pass: speed feedback
      5'd5:  w = '{ALU_PASSA, SAT_NONE, SRC_ZERO, SRC_ZERO, DST_NONE,
                   1'b1, SRC_CHIN, MB_K1000, 1'b0, J_NEXT};
      5'd6:  w = '{ALU_PASSA, SAT_NONE, SRC_PROD, SRC_ZERO, DST_NONE,
                   1'b0, SRC_ZERO, MB_K1000, 1'b1, J_NEXT};
      5'd7:  w = '{ALU_PASSA, SAT_NONE, SRC_ZERO, SRC_ZERO, DST_NONE,
                   1'b0, SRC_ZERO, MB_K1000, 1'b0, J_WAIT};
      // error, rate numerator, integrator
      5'd8:  w = '{ALU_SUB, SAT_S32, SRC_TGT, SRC_QUOT, DST_T0,
                   1'b0, SRC_ZERO, MB_K1000, 1'b0, J_NEXT};
      5'd9:  w = '{ALU_SUB, SAT_NONE, SRC_T0, SRC_EPREV, DST_T1,
                   1'b1, SRC_T0, MB_PERIOD, 1'b0, J_NEXT};
      5'd10: w = '{ALU_PASSB, SAT_NONE, SRC_T1, SRC_T0, DST_EPREV,
                   1'b0, SRC_ZERO, MB_K1000, 1'b1, J_NEXT};
      5'd11: w = '{ALU_ADD, SAT_S48, SRC_SUM, SRC_PROD, DST_T2,
                   1'b1, SRC_T0, MB_GP, 1'b0, J_NEXT};
      // gain products into t1
      5'd12: w = '{ALU_PASSA, SAT_NONE, SRC_PROD, SRC_ZERO, DST_T1,
                   1'b1, SRC_T2LO, MB_GI, 1'b0, J_NEXT};
      5'd13: w = '{ALU_ADD, SAT_NONE, SRC_T1, SRC_PROD, DST_T1,
                   1'b1, SRC_T2HI, MB_GI, 1'b0, J_NEXT};
      5'd14: w = '{ALU_ADD, SAT_NONE, SRC_T1, SRC_PRODSH, DST_T1,
                   1'b0, SRC_ZERO, MB_K1000, 1'b0, J_NEXT};
      5'd15: w = '{ALU_PASSA, SAT_NONE, SRC_T2, SRC_ZERO, DST_SUM,
                   1'b0, SRC_ZERO, MB_K1000, 1'b0, J_NEXT};
      5'd16: w = '{ALU_PASSA, SAT_NONE, SRC_ZERO, SRC_ZERO, DST_NONE,
                   1'b0, SRC_ZERO, MB_K1000, 1'b0, J_WAIT};
      5'd17: w = '{ALU_PASSA, SAT_NONE, SRC_ZERO, SRC_ZERO, DST_NONE,
                   1'b1, SRC_QUOT, MB_GD, 1'b0, J_NEXT};
      5'd18: w = '{ALU_ADD, SAT_NONE, SRC_T1, SRC_PROD, DST_T1,
                   1'b0, SRC_ZERO, MB_K1000, 1'b0, J_NEXT};
      5'd19: w = '{ALU_RND, SAT_S32, SRC_T1, SRC_ZERO, DST_PCH,
                   1'b0, SRC_ZERO, MB_K1000, 1'b0, J_LOOP};
      // drive mix
      5'd20: w = '{ALU_SUB, SAT_S16, SRC_PX, SRC_PW, DST_T0,
                   1'b0, SRC_ZERO, MB_K1000, 1'b0, J_NEXT};
      5'd21: w = '{ALU_ADD, SAT_S16, SRC_PX, SRC_PW, DST_T2,
                   1'b0, SRC_ZERO, MB_K1000, 1'b0, J_NEXT};
      5'd22: w = '{ALU_PASSA, SAT_NONE, SRC_ZERO, SRC_ZERO, DST_NONE,
                   1'b0, SRC_ZERO, MB_K1000, 1'b0, J_DONE};
      default: w = UC_NOP;
    endcase
    return w;
  endfunction

  // clamp to a signed range of w bits
  function automatic logic signed [DP_W-1:0] sat_to(input logic signed [DP_W:0] v,
                                                    input int unsigned w);
    logic signed [DP_W:0] hi;
    logic signed [DP_W:0] lo;
    hi = ((DP_W+1)'(1) <<< (w - 1)) - (DP_W+1)'(1);
    lo = -hi - (DP_W+1)'(1);
    if (v > hi) return DP_W'(hi);
    else if (v < lo) return DP_W'(lo);
    else return DP_W'(v);
  endfunction

endpackage

`default_nettype wire

@@ sv/dvpid_if.sv @@
`default_nettype none

interface dvpid_in_if;
  logic valid;
  logic ready;
  logic signed [dvpid_pkg::CNT_W-1:0] left_count;
  logic signed [dvpid_pkg::CNT_W-1:0] right_count;
  logic [dvpid_pkg::PERIOD_W-1:0] tick_period_ms;
  modport source (output valid, left_count, right_count, tick_period_ms, input ready);
  modport sink (input valid, left_count, right_count, tick_period_ms, output ready);
endinterface

interface dvpid_out_if;
  logic valid;
  logic ready;
  logic signed [dvpid_pkg::DRIVE_W-1:0] left_drive;
  logic signed [dvpid_pkg::DRIVE_W-1:0] right_drive;
  modport source (output valid, left_drive, right_drive, input ready);
  modport sink (input valid, left_drive, right_drive, output ready);
endinterface

interface dvpid_cfg_if;
  logic valid;
  logic ready;
  logic [dvpid_pkg::CFG_IDX_W-1:0] index;
  logic [dvpid_pkg::GAIN_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ sv/differential_drive_velocity_pid.sv @@
// channel  dir  handshake    payload
// sample   in   valid/ready  left_count, right_count, tick_period_ms
// drive    out  valid/ready  left_drive, right_drive
// cfg      in   valid/ready  index, data (ready high outside reset)
//
// between requests the sequencer returns to idle, with sample ready high.
// the shared divider (4 quotient bits per clock) runs four times per request,
// and the sequencer waits on its busy flag for each of those quotients.
// rst is synchronous; it clears the sequencer, the loop state and the configuration registers.
// a result that is not taken holds the sequencer on its last step, and sample stays
// not ready until the new result moves into the output register.
`default_nettype none
`include "assert_macros.svh"

module differential_drive_velocity_pid (
  input  logic clk,
  input  logic rst,
  dvpid_in_if.sink     sample,
  dvpid_out_if.source  drive,
  dvpid_cfg_if.sink    cfg
);

  localparam int unsigned W = dvpid_pkg::DP_W;

  // sequencer
  logic run;
  logic ch;
  logic [dvpid_pkg::UC_PC_W-1:0] pc;
  dvpid_pkg::uc_t uc;
  logic out_valid;

  // configuration
  logic signed [dvpid_pkg::SPEED_W-1:0] tgt_fwd;
  logic signed [dvpid_pkg::SPEED_W-1:0] tgt_trn;
  logic [dvpid_pkg::GAIN_W-1:0] g_fp, g_fi, g_fd, g_tp, g_ti, g_td;

  // request and loop state
  logic signed [dvpid_pkg::CNT_W-1:0] lc, rc, lprev, rprev;
  logic [dvpid_pkg::PERIOD_W-1:0] period;
  logic signed [dvpid_pkg::SUM_W-1:0] sum_f, sum_t;
  logic signed [31:0] eprev_f, eprev_t;

  // working registers
  logic signed [31:0] t0;
  logic signed [W-1:0] t1;
  logic signed [dvpid_pkg::SUM_W-1:0] t2;
  logic signed [32:0] chin0, chin1;
  logic signed [31:0] px, pw;
  logic signed [dvpid_pkg::PROD_W-1:0] prod;
  logic signed [dvpid_pkg::DRIVE_W-1:0] out_l, out_r;

  // datapath wires
  logic signed [W-1:0] a_v, b_v, alu_r;
  logic signed [W:0] alu_s;
  logic signed [dvpid_pkg::MA_W-1:0] ma_v;
  logic signed [dvpid_pkg::MB_W-1:0] mb_v;
  logic div_busy;
  logic signed [dvpid_pkg::DIV_NUM_W-1:0] div_q;
  logic sample_acc;
  logic drive_acc;
  logic done_go;

  function automatic logic signed [W-1:0] src_val(input dvpid_pkg::src_t s);
    logic signed [W-1:0] v;
    v = '0;
    case (s)
      dvpid_pkg::SRC_ZERO:   v = '0;
      dvpid_pkg::SRC_LC:     v = W'(lc);
      dvpid_pkg::SRC_RC:     v = W'(rc);
      dvpid_pkg::SRC_LPREV:  v = W'(lprev);
      dvpid_pkg::SRC_RPREV:  v = W'(rprev);
      dvpid_pkg::SRC_T0:     v = W'(t0);
      dvpid_pkg::SRC_T1:     v = t1;
      dvpid_pkg::SRC_T2:     v = W'(t2);
      dvpid_pkg::SRC_T2LO:   v = W'({1'b0, t2[dvpid_pkg::ACC_SPLIT-1:0]});
      dvpid_pkg::SRC_T2HI:   v = W'($signed(t2[dvpid_pkg::SUM_W-1:dvpid_pkg::ACC_SPLIT]));
      dvpid_pkg::SRC_PROD:   v = W'(prod);
      dvpid_pkg::SRC_PRODSH: v = W'(prod) <<< dvpid_pkg::ACC_SPLIT;
      dvpid_pkg::SRC_QUOT:   v = W'(div_q);
      dvpid_pkg::SRC_CHIN:   v = ch ? W'(chin1) : W'(chin0);
      dvpid_pkg::SRC_TGT:    v = ch ? W'(tgt_trn) : W'(tgt_fwd);
      dvpid_pkg::SRC_SUM:    v = ch ? W'(sum_t) : W'(sum_f);
      dvpid_pkg::SRC_EPREV:  v = ch ? W'(eprev_t) : W'(eprev_f);
      dvpid_pkg::SRC_PX:     v = W'(px);
      dvpid_pkg::SRC_PW:     v = W'(pw);
      default:               v = '0;
    endcase
    return v;
  endfunction

  assign uc = dvpid_pkg::uc_rom(pc);

  always_comb begin
    a_v = src_val(uc.a);
    b_v = src_val(uc.b);
    ma_v = dvpid_pkg::MA_W'(src_val(uc.ma));
  end

  always_comb begin
    case (uc.mb)
      dvpid_pkg::MB_K1000:  mb_v = dvpid_pkg::K_MS_PER_S;
      dvpid_pkg::MB_PERIOD: mb_v = dvpid_pkg::MB_W'(period);
      dvpid_pkg::MB_GP:     mb_v = dvpid_pkg::MB_W'(ch ? g_tp : g_fp);
      dvpid_pkg::MB_GI:     mb_v = dvpid_pkg::MB_W'(ch ? g_ti : g_fi);
      dvpid_pkg::MB_GD:     mb_v = dvpid_pkg::MB_W'(ch ? g_td : g_fd);
      default:              mb_v = '0;
    endcase
  end

  // alu: add, subtract, pass or round, then wrap or clamp
  always_comb begin
    case (uc.op)
      dvpid_pkg::ALU_ADD:   alu_s = (W+1)'(a_v) + (W+1)'(b_v);
      dvpid_pkg::ALU_SUB:   alu_s = (W+1)'(a_v) - (W+1)'(b_v);
      dvpid_pkg::ALU_PASSA: alu_s = (W+1)'(a_v);
      dvpid_pkg::ALU_PASSB: alu_s = (W+1)'(b_v);
      // divide by 256 toward zero
      dvpid_pkg::ALU_RND:   alu_s = ((W+1)'(a_v) + (a_v[W-1] ? (W+1)'(255) : (W+1)'(0))) >>> 8;
      default:              alu_s = '0;
    endcase
    case (uc.sat)
      dvpid_pkg::SAT_NONE: alu_r = W'(alu_s);
      dvpid_pkg::SAT_W32:  alu_r = W'($signed(alu_s[31:0]));
      dvpid_pkg::SAT_S16:  alu_r = dvpid_pkg::sat_to(alu_s, dvpid_pkg::DRIVE_W);
      dvpid_pkg::SAT_S32:  alu_r = dvpid_pkg::sat_to(alu_s, 32);
      dvpid_pkg::SAT_S48:  alu_r = dvpid_pkg::sat_to(alu_s, dvpid_pkg::SUM_W);
      default:             alu_r = W'(alu_s);
    endcase
  end

  dvpid_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (run && uc.div_start),
    .num   (dvpid_pkg::DIV_NUM_W'(a_v)),
    .den   (period),
    .busy  (div_busy),
    .quot  (div_q)
  );

  assign sample.ready = !run && !rst;
  assign cfg.ready = !rst;
  assign drive.valid = out_valid;
  assign drive.left_drive = out_l;
  assign drive.right_drive = out_r;

  assign sample_acc = sample.valid && sample.ready;
  assign drive_acc = out_valid && drive.ready;
  assign done_go = run && (uc.jmp == dvpid_pkg::J_DONE) && (!out_valid || drive.ready);

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      pc <= '0;
      ch <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (drive_acc && !done_go) out_valid <= 1'b0;
      if (!run) begin
        if (sample_acc) begin
          run <= 1'b1;
          pc <= '0;
          ch <= 1'b0;
        end
      end else begin
        case (uc.jmp)
          dvpid_pkg::J_NEXT: pc <= pc + dvpid_pkg::UC_PC_W'(1);
          dvpid_pkg::J_WAIT: if (!div_busy) pc <= pc + dvpid_pkg::UC_PC_W'(1);
          dvpid_pkg::J_LOOP: begin
            if (!ch) begin
              ch <= 1'b1;
              pc <= dvpid_pkg::UC_LOOP;
            end else begin
              pc <= pc + dvpid_pkg::UC_PC_W'(1);
            end
          end
          dvpid_pkg::J_DONE: begin
            if (done_go) begin
              run <= 1'b0;
              out_valid <= 1'b1;
            end
          end
          default: pc <= pc;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done_go) begin
      out_l <= t0[dvpid_pkg::DRIVE_W-1:0];
      out_r <= t2[dvpid_pkg::DRIVE_W-1:0];
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tgt_fwd <= '0;
      tgt_trn <= '0;
      g_fp <= dvpid_pkg::RST_FWD_P;
      g_fi <= '0;
      g_fd <= '0;
      g_tp <= dvpid_pkg::RST_TRN_P;
      g_ti <= '0;
      g_td <= dvpid_pkg::RST_TRN_D;
    end else if (cfg.valid) begin
      case (cfg.index)
        dvpid_pkg::REG_TGT_FWD: tgt_fwd <= $signed(cfg.data);
        dvpid_pkg::REG_TGT_TRN: tgt_trn <= $signed(cfg.data);
        dvpid_pkg::REG_FWD_P:   g_fp <= cfg.data;
        dvpid_pkg::REG_FWD_I:   g_fi <= cfg.data;
        dvpid_pkg::REG_FWD_D:   g_fd <= cfg.data;
        dvpid_pkg::REG_TRN_P:   g_tp <= cfg.data;
        dvpid_pkg::REG_TRN_I:   g_ti <= cfg.data;
        dvpid_pkg::REG_TRN_D:   g_td <= cfg.data;
        default: ;
      endcase
    end
  end

  // loop state that survives between requests
  always_ff @(posedge clk) begin
    if (rst) begin
      lprev <= '0;
      rprev <= '0;
      sum_f <= '0;
      sum_t <= '0;
      eprev_f <= '0;
      eprev_t <= '0;
    end else if (run) begin
      case (uc.dst)
        dvpid_pkg::DST_PREV: begin
          lprev <= lc;
          rprev <= rc;
        end
        dvpid_pkg::DST_SUM: begin
          if (ch) sum_t <= dvpid_pkg::SUM_W'(alu_r);
          else sum_f <= dvpid_pkg::SUM_W'(alu_r);
        end
        dvpid_pkg::DST_EPREV: begin
          if (ch) eprev_t <= 32'(alu_r);
          else eprev_f <= 32'(alu_r);
        end
        default: ;
      endcase
    end
  end

  // working registers, request latch and multiplier
  always_ff @(posedge clk) begin
    if (sample_acc) begin
      lc <= sample.left_count;
      rc <= sample.right_count;
      // a zero period counts as one
      period <= (sample.tick_period_ms == '0) ? dvpid_pkg::PERIOD_W'(1)
                                              : sample.tick_period_ms;
    end
    if (run && uc.mul_en) begin
      prod <= dvpid_pkg::PROD_W'(dvpid_pkg::PROD_W'(ma_v) * dvpid_pkg::PROD_W'(mb_v));
    end
    if (run) begin
      case (uc.dst)
        dvpid_pkg::DST_T0:    t0 <= 32'(alu_r);
        dvpid_pkg::DST_T1:    t1 <= alu_r;
        dvpid_pkg::DST_T2:    t2 <= dvpid_pkg::SUM_W'(alu_r);
        dvpid_pkg::DST_CHIN0: chin0 <= 33'(alu_r);
        dvpid_pkg::DST_CHIN1: chin1 <= 33'(alu_r);
        dvpid_pkg::DST_PCH: begin
          if (ch) pw <= 32'(alu_r);
          else px <= 32'(alu_r);
        end
        default: ;
      endcase
    end
  end

  `DVP_ASSERT_IMP(a_div_start_idle, run && uc.div_start, !div_busy,
    "divider restarted while busy")
  `DVP_ASSERT_IMP(a_pc_in_program, run, pc < dvpid_pkg::UC_PC_W'(dvpid_pkg::UC_LEN),
    "step counter left the program")
  `DVP_ASSERT_IMP(a_mix_after_both, run && pc >= dvpid_pkg::UC_EPI, ch,
    "drive mix reached before turn loop")
  `DVP_ASSERT_NEXT(a_done_loads, done_go, !run && out_valid && sample.ready,
    "finished request did not load the output register")

endmodule

`default_nettype wire

@@ sv/dvpid_div.sv @@
`default_nettype none

// signed by unsigned divide, truncating, four quotient bits per clock
module dvpid_div (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic signed [dvpid_pkg::DIV_NUM_W-1:0] num,
  input  logic [dvpid_pkg::DIV_DEN_W-1:0] den,
  output logic busy,
  output logic signed [dvpid_pkg::DIV_NUM_W-1:0] quot
);

  logic neg;
  logic [dvpid_pkg::DIV_DEN_W-1:0] dvs;
  logic [dvpid_pkg::DIV_DEN_W-1:0] rem;
  logic [dvpid_pkg::DIV_DEN_W-1:0] rem_next;
  logic [dvpid_pkg::DIV_NUM_W-1:0] qsh;
  logic [dvpid_pkg::DIV_NUM_W-1:0] qsh_next;
  logic [dvpid_pkg::DIV_DEN_W:0] trial;
  logic [dvpid_pkg::DIV_CNT_W-1:0] cnt;

  always_comb begin
    rem_next = rem;
    qsh_next = qsh;
    trial = '0;
    for (int k = 0; k < dvpid_pkg::DIV_BITS; k++) begin
      trial = {rem_next, qsh_next[dvpid_pkg::DIV_NUM_W-1]};
      qsh_next = {qsh_next[dvpid_pkg::DIV_NUM_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs}) begin
        rem_next = dvpid_pkg::DIV_DEN_W'(trial - {1'b0, dvs});
        qsh_next[0] = 1'b1;
      end else begin
        rem_next = trial[dvpid_pkg::DIV_DEN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= dvpid_pkg::DIV_CNT_W'(dvpid_pkg::DIV_STEPS);
      neg <= num[dvpid_pkg::DIV_NUM_W-1];
      dvs <= den;
      rem <= '0;
      qsh <= num[dvpid_pkg::DIV_NUM_W-1] ? dvpid_pkg::DIV_NUM_W'(-num)
                                         : dvpid_pkg::DIV_NUM_W'(num);
    end else if (busy) begin
      rem <= rem_next;
      qsh <= qsh_next;
      cnt <= cnt - dvpid_pkg::DIV_CNT_W'(1);
      if (cnt == dvpid_pkg::DIV_CNT_W'(1)) busy <= 1'b0;
    end
  end

  assign quot = neg ? -$signed(qsh) : $signed(qsh);

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;

  typedef logic signed [79:0] wide_t;

  typedef struct {
    logic signed [dvpid_pkg::DRIVE_W-1:0] left_drive;
    logic signed [dvpid_pkg::DRIVE_W-1:0] right_drive;
  } drive_t;

  typedef enum {SET_TOP, SET_BOTTOM, SET_RANDOM} setting_t;

  localparam wide_t W16_HI = (wide_t'(1) <<< 15) - wide_t'(1);
  localparam wide_t W16_LO = -(wide_t'(1) <<< 15);
  localparam wide_t W32_HI = (wide_t'(1) <<< 31) - wide_t'(1);
  localparam wide_t W32_LO = -(wide_t'(1) <<< 31);
  localparam wide_t W48_HI = (wide_t'(1) <<< 47) - wide_t'(1);
  localparam wide_t W48_LO = -(wide_t'(1) <<< 47);
  localparam wide_t W64_HI = (wide_t'(1) <<< 63) - wide_t'(1);
  localparam wide_t W64_LO = -(wide_t'(1) <<< 63);
  localparam int MS_PER_S = 1000;
  localparam int Q8_ONE = 256;

  localparam int PHASES = 5;
  localparam int PHASE_ITEMS = 246;
  localparam int RUN_LEN = 140;
  localparam int HOLD_CYCLES = 600;
  localparam int SEND_IDLE [PHASES] = '{0, 63, 0, 25, 0};
  localparam int STALL [PHASES] = '{0, 0, 63, 25, 0};
  localparam setting_t PHASE_SET [PHASES] =
    '{SET_RANDOM, SET_BOTTOM, SET_RANDOM, SET_TOP, SET_RANDOM};

  class drive_checker;
    logic signed [dvpid_pkg::SPEED_W-1:0] tgt_fwd;
    logic signed [dvpid_pkg::SPEED_W-1:0] tgt_trn;
    int gain [6];
    logic [dvpid_pkg::CNT_W-1:0] left_last;
    logic [dvpid_pkg::CNT_W-1:0] right_last;
    longint fwd_integ;
    longint trn_integ;
    int fwd_err_last;
    int trn_err_last;
    drive_t pending_drives [$];
    int mismatches;

    function new();
      tgt_fwd = '0;
      tgt_trn = '0;
      gain = '{int'(dvpid_pkg::RST_FWD_P), 0, 0, int'(dvpid_pkg::RST_TRN_P), 0,
               int'(dvpid_pkg::RST_TRN_D)};
      left_last = '0;
      right_last = '0;
      fwd_integ = 0;
      trn_integ = 0;
      fwd_err_last = 0;
      trn_err_last = 0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [dvpid_pkg::CFG_IDX_W-1:0] idx,
                            logic [dvpid_pkg::GAIN_W-1:0] val);
      case (idx)
        dvpid_pkg::REG_TGT_FWD: tgt_fwd = val;
        dvpid_pkg::REG_TGT_TRN: tgt_trn = val;
        default: gain[idx - dvpid_pkg::REG_FWD_P] = int'(val);
      endcase
    endfunction

    function wide_t clip(wide_t v, wide_t lo, wide_t hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // one loop: updates its integrator and last error, returns the 32-bit output
    function wide_t pid_out(wide_t fb, logic signed [dvpid_pkg::SPEED_W-1:0] target,
                            wide_t period,
                            inout longint integ, inout int err_last,
                            input int gp, input int gi, input int gd);
      wide_t err;
      wide_t rate;
      wide_t acc;
      wide_t total;
      err = clip(wide_t'(target) - fb, W32_LO, W32_HI);
      rate = (err - wide_t'(err_last)) / period;
      acc = clip(wide_t'(integ) + err * period, W48_LO, W48_HI);
      // exact sum, then clamp to 64 bits like a saturating add
      total = clip(wide_t'(gp) * err + wide_t'(gd) * rate + wide_t'(gi) * acc,
                   W64_LO, W64_HI);
      integ = longint'(acc);
      err_last = int'(err);
      return clip(total / wide_t'(Q8_ONE), W32_LO, W32_HI);
    endfunction

    function void take_sample(logic [dvpid_pkg::CNT_W-1:0] lc,
                              logic [dvpid_pkg::CNT_W-1:0] rc,
                              logic [dvpid_pkg::PERIOD_W-1:0] per);
      wide_t period;
      wide_t dl;
      wide_t dr;
      wide_t px;
      wide_t pw;
      drive_t want;
      period = (per == '0) ? wide_t'(1) : wide_t'(int'(per));
      dl = wide_t'(int'(lc - left_last));
      dr = wide_t'(int'(rc - right_last));
      left_last = lc;
      right_last = rc;
      px = pid_out((dr + dl) * wide_t'(MS_PER_S) / period, tgt_fwd, period,
                   fwd_integ, fwd_err_last, gain[0], gain[1], gain[2]);
      pw = pid_out((dr - dl) * wide_t'(MS_PER_S) / period, tgt_trn, period,
                   trn_integ, trn_err_last, gain[3], gain[4], gain[5]);
      want.left_drive = dvpid_pkg::DRIVE_W'(clip(px - pw, W16_LO, W16_HI));
      want.right_drive = dvpid_pkg::DRIVE_W'(clip(px + pw, W16_LO, W16_HI));
      pending_drives.push_back(want);
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", msg);
    endfunction

    function void check_drive(logic signed [dvpid_pkg::DRIVE_W-1:0] got_left,
                              logic signed [dvpid_pkg::DRIVE_W-1:0] got_right);
      drive_t want;
      if (pending_drives.size() == 0) begin
        flag($sformatf("drive %0d/%0d with no request pending", got_left, got_right));
      end else begin
        want = pending_drives.pop_front();
        if (want.left_drive !== got_left)
          flag($sformatf("left_drive expected %0d got %0d", want.left_drive, got_left));
        if (want.right_drive !== got_right)
          flag($sformatf("right_drive expected %0d got %0d", want.right_drive, got_right));
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_asked = 0;
  drive_checker sb;

  dvpid_in_if sample();
  dvpid_out_if drive();
  dvpid_cfg_if cfg();

  differential_drive_velocity_pid u_top (
    .clk(clk),
    .rst(rst),
    .sample(sample),
    .drive(drive),
    .cfg(cfg)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // drive side: random stalls, plus one long hold-off on request
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    drive.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_asked != hold_seen) begin
        hold_seen = hold_asked;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        drive.ready <= 1'b0;
      end else begin
        drive.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (drive.valid && drive.ready) sb.check_drive(drive.left_drive, drive.right_drive);
      if (sample.valid && sample.ready)
        sb.take_sample(sample.left_count, sample.right_count, sample.tick_period_ms);
      if (cfg.valid && cfg.ready) sb.write_reg(cfg.index, cfg.data);
    end
  end

  task automatic send_tick(input logic [dvpid_pkg::CNT_W-1:0] lc,
                           input logic [dvpid_pkg::CNT_W-1:0] rc,
                           input logic [dvpid_pkg::PERIOD_W-1:0] per);
    sample.valid <= 1'b1;
    sample.left_count <= lc;
    sample.right_count <= rc;
    sample.tick_period_ms <= per;
    do @(posedge clk); while (!sample.ready);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      sample.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // one edge first so the last accepted request is already noted
  task automatic drain_drives();
    sample.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_drives.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // leaves valid high; the caller lowers it after the last write
  task automatic write_reg(input logic [dvpid_pkg::CFG_IDX_W-1:0] idx,
                           input logic [dvpid_pkg::GAIN_W-1:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    do @(posedge clk); while (!cfg.ready);
  endtask

  function automatic logic [dvpid_pkg::GAIN_W-1:0] rand_gain();
    return ($urandom_range(7) == 0) ? dvpid_pkg::GAIN_W'($urandom)
                                    : dvpid_pkg::GAIN_W'($urandom_range(0, 2047));
  endfunction

  task automatic apply_setting(input setting_t kind);
    logic [dvpid_pkg::GAIN_W-1:0] v [8];
    case (kind)
      SET_TOP: begin
        v = '{16'h7FFF, 16'h8000, 16'hFFFF, 16'hFFFF, 16'hFFFF,
              16'hFFFF, 16'hFFFF, 16'hFFFF};
      end
      SET_BOTTOM: begin
        v = '{16'h8000, 16'h7FFF, 16'h0000, 16'h0001, 16'h0000,
              16'h0001, 16'h0000, 16'h0000};
      end
      default: begin
        v = '{dvpid_pkg::GAIN_W'($urandom), dvpid_pkg::GAIN_W'($urandom), rand_gain(),
              rand_gain(), rand_gain(), rand_gain(), rand_gain(), rand_gain()};
      end
    endcase
    write_reg(dvpid_pkg::REG_TGT_FWD, v[0]);
    write_reg(dvpid_pkg::REG_TGT_TRN, v[1]);
    write_reg(dvpid_pkg::REG_FWD_P, v[2]);
    write_reg(dvpid_pkg::REG_FWD_I, v[3]);
    write_reg(dvpid_pkg::REG_FWD_D, v[4]);
    write_reg(dvpid_pkg::REG_TRN_P, v[5]);
    write_reg(dvpid_pkg::REG_TRN_I, v[6]);
    write_reg(dvpid_pkg::REG_TRN_D, v[7]);
    cfg.valid <= 1'b0;
  endtask

  initial begin
    int sent;
    int roll;
    int spd_l;
    int spd_r;
    logic [dvpid_pkg::CNT_W-1:0] lcur;
    logic [dvpid_pkg::CNT_W-1:0] rcur;
    logic [dvpid_pkg::CNT_W-1:0] run_step;
    logic [dvpid_pkg::PERIOD_W-1:0] per;
    sb = new();
    sample.valid <= 1'b0;
    sample.left_count <= '0;
    sample.right_count <= '0;
    sample.tick_period_ms <= '0;
    cfg.valid <= 1'b0;
    cfg.index <= dvpid_pkg::REG_TGT_FWD;
    cfg.data <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed ticks under the reset gains
    send_tick(32'd0, 32'd0, 10'd1);
    send_tick(32'd10, 32'd30, 10'd5);
    send_tick(32'd20, 32'd60, 10'd0);          // zero period
    send_tick(32'd40, 32'd90, 10'd1023);       // period above 1000
    send_tick(32'd50, 32'd100, 10'd1000);
    send_tick(32'h7FFFFFFF, 32'h80000000, 10'd1);  // huge error, drives saturate
    send_tick(32'h80000000, 32'h7FFFFFFF, 10'd1);
    send_tick(32'hFFFFFFF0, 32'hFFFFFFFF, 10'd2);
    send_tick(32'h00000010, 32'h00000005, 10'd2);  // counts wrap through zero
    send_tick(32'hFFFFFFFF, 32'h00000000, 10'h3FF);
    send_tick(32'h00000000, 32'hFFFFFFFF, 10'h200);
    send_tick(32'h55555555, 32'hAAAAAAAA, 10'h155);
    send_tick(32'hAAAAAAAA, 32'h55555555, 10'h2AA);
    send_tick(32'hAAAAAAAA, 32'h55555555, 10'd7);
    drain_drives();
    lcur = 32'hAAAAAAAA;
    rcur = 32'h55555555;

    for (int ph = 0; ph < PHASES; ph++) begin
      send_idle_pct = SEND_IDLE[ph];
      stall_pct = STALL[ph];
      apply_setting(PHASE_SET[ph]);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if (ph == 0 && sent == 40) hold_asked++;
        if (ph == 2 && sent == 120) drain_drives();
        if (ph >= 3 && sent == 100) begin
          // runaway wheels: error pinned at a rail until the integrator saturates
          run_step = (ph == 3) ? 32'h7FFFFFFF : 32'h80000000;
          repeat (RUN_LEN) begin
            lcur += run_step;
            rcur += run_step;
            send_tick(lcur, rcur, 10'd1023);
          end
          sent += RUN_LEN;
        end else begin
          roll = $urandom_range(99);
          spd_l = int'($urandom_range(0, 4000)) - 2000;
          spd_r = int'($urandom_range(0, 4000)) - 2000;
          if (roll < 78) begin
            per = ($urandom_range(9) == 0) ? dvpid_pkg::PERIOD_W'($urandom_range(1, 1000))
                                           : dvpid_pkg::PERIOD_W'($urandom_range(1, 40));
            lcur += dvpid_pkg::CNT_W'(spd_l * int'(per) / MS_PER_S);
            rcur += dvpid_pkg::CNT_W'(spd_r * int'(per) / MS_PER_S);
          end else if (roll < 86) begin
            lcur += dvpid_pkg::CNT_W'($urandom);
            rcur += dvpid_pkg::CNT_W'($urandom);
            per = dvpid_pkg::PERIOD_W'($urandom_range(0, 1023));
          end else if (roll < 93) begin
            lcur = dvpid_pkg::CNT_W'($urandom);
            rcur = dvpid_pkg::CNT_W'($urandom);
            per = dvpid_pkg::PERIOD_W'($urandom_range(0, 1023));
          end else begin
            case ($urandom_range(4))
              0: per = 10'd0;
              1: per = 10'd1;
              2: per = 10'd1000;
              3: per = 10'd1001;
              default: per = 10'd1023;
            endcase
            lcur += dvpid_pkg::CNT_W'(spd_l);
            rcur += dvpid_pkg::CNT_W'(spd_r);
          end
          send_tick(lcur, rcur, per);
          sent++;
        end
      end
      drain_drives();
    end

    repeat (100) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_drives.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("tb: done, errors");
    $finish;
  end

endmodule
